// ===== hw/rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// shared types, codes and defaults of the priority ready queue
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int DEF_NUM_THREADS = 64;
   localparam int DEF_NUM_LEVELS  = 64;
   localparam int MASK_WORD_BITS  = 32;

   // operation codes
   localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
   localparam logic [1:0] MODE_DEQUEUE  = 2'd1;
   localparam logic [1:0] MODE_REMOVE   = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_ABSENT    = 2'd2;
   localparam logic [1:0] ST_DUPLICATE = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] thread_id;
      logic [5:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [5:0] out_thread;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== hw/rtl/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue
// thread ready queue: per-level linked fifos in ram, bitmap of busy levels
// ----------------------------------------------------------------------------
//  channel   ports                   direction  transfer
//  request   start, busy, req_data   in         start high while busy low
//  response  rsp_valid, rsp_data     out        rsp_valid high for one cycle
//
//  every request gives exactly one response; busy is high from the transfer
//  until the response strobe, then low again, except where the request is
//  answered from idle; enqueue answers from its check on an empty level or a
//  duplicate, else sets the new tail and then links the old tail; dequeue
//  scans the 32-level mask words from the top and answers empty when all are
//  clear; remove answers from its check when absent, else reads the head and
//  walks the list; out of range ids and the unused mode answer from idle
//  each step waits on the registered read of the thread or level ram
//  after reset a clearing pass writes NUM_THREADS thread entries, busy high
//  the receiver cannot stall, so the response is only a strobe
// ----------------------------------------------------------------------------
module priority_ready_queue #(
   parameter int NUM_THREADS = prq_pkg::DEF_NUM_THREADS,
   parameter int NUM_LEVELS  = prq_pkg::DEF_NUM_LEVELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prq_pkg::req_type req_data,
   output logic             rsp_valid,
   output prq_pkg::rsp_type rsp_data
);

   localparam int TW  = $clog2(NUM_THREADS);           // thread index
   localparam int NW  = TW + 1;                         // link incl end mark
   localparam int LW  = $clog2(NUM_LEVELS);             // level index
   localparam int MW  = (NUM_LEVELS + prq_pkg::MASK_WORD_BITS - 1)
                        / prq_pkg::MASK_WORD_BITS;      // mask words
   localparam int WW  = (MW > 1) ? $clog2(MW) : 1;
   localparam int MB  = MW * prq_pkg::MASK_WORD_BITS;
   localparam int TEW = NW + LW + 1;                    // thread entry
   localparam int LEW = 2 * TW;                         // level entry

   localparam logic [NW-1:0] LINK_END = NW'(NUM_THREADS);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_ENQ_CHK  = 4'd2;
   localparam logic [3:0] S_ENQ_TAIL = 4'd3;
   localparam logic [3:0] S_ENQ_LINK = 4'd4;
   localparam logic [3:0] S_DEQ_SCAN = 4'd5;
   localparam logic [3:0] S_DEQ_HEAD = 4'd6;
   localparam logic [3:0] S_DEQ_POP  = 4'd7;
   localparam logic [3:0] S_REM_CHK  = 4'd8;
   localparam logic [3:0] S_REM_HEAD = 4'd9;
   localparam logic [3:0] S_REM_WALK = 4'd10;

   // highest set bit of one mask word
   function automatic logic [4:0] find_msb(input logic [31:0] w);
      logic [4:0] idx;
      idx = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (w[b]) begin
            idx = 5'(b);
         end
      end
      return idx;
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [TW-1:0]     tid_ff, tid_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [WW-1:0]     word_ff, word_in;
   logic [TW-1:0]     prev_ff, prev_in;
   logic [TW-1:0]     head_ff, head_in;
   logic [TW-1:0]     tail_ff, tail_in;
   logic [NW-1:0]     tnext_ff, tnext_in;
   logic [TW-1:0]     clr_ff, clr_in;
   logic [MB-1:0]     mask_ff, mask_in;
   logic              rsp_valid_ff, rsp_valid_in;
   prq_pkg::rsp_type  rsp_ff, rsp_in;

   // thread ram: {next link, level, queued}
   logic              t_we;
   logic [TW-1:0]     t_waddr, t_raddr;
   logic [TEW-1:0]    t_wdata, t_rdata;
   // level ram: {head, tail}
   logic              l_we;
   logic [LW-1:0]     l_waddr, l_raddr;
   logic [LEW-1:0]    l_wdata, l_rdata;

   logic [NW-1:0]     rd_next;
   logic [LW-1:0]     rd_level;
   logic              rd_queued;
   logic [TW-1:0]     rd_head, rd_tail;
   logic [31:0]       scan_word;
   logic              tid_oob;
   logic [LW-1:0]     req_level;

   assign rd_next   = t_rdata[TEW-1 -: NW];
   assign rd_level  = t_rdata[LW:1];
   assign rd_queued = t_rdata[0];
   assign rd_head   = l_rdata[LEW-1 -: TW];
   assign rd_tail   = l_rdata[TW-1:0];
   assign scan_word = mask_ff[word_ff * prq_pkg::MASK_WORD_BITS +: 32];

   // ids past the thread count are answered as absent
   assign tid_oob   = 32'(req_data.thread_id) >= NUM_THREADS;
   // priority saturates at the top level
   assign req_level = (32'(req_data.priority_req) >= NUM_LEVELS) ?
                      LW'(NUM_LEVELS - 1) : LW'(req_data.priority_req);

   prq_ram #(.WIDTH(TEW), .DEPTH(NUM_THREADS)) u_thread_ram (
      .clock (clock),
      .we    (t_we),
      .waddr (t_waddr),
      .wdata (t_wdata),
      .raddr (t_raddr),
      .rdata (t_rdata)
   );

   prq_ram #(.WIDTH(LEW), .DEPTH(NUM_LEVELS)) u_level_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (l_wdata),
      .raddr (l_raddr),
      .rdata (l_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      tid_in       = tid_ff;
      lvl_in       = lvl_ff;
      word_in      = word_ff;
      prev_in      = prev_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      tnext_in     = tnext_ff;
      clr_in       = clr_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      t_we         = 1'b0;
      t_waddr      = tid_ff;
      t_wdata      = '0;
      t_raddr      = tid_ff;
      l_we         = 1'b0;
      l_waddr      = lvl_ff;
      l_wdata      = '0;
      l_raddr      = lvl_ff;

      case (state_ff)
         S_CLEAR: begin
            // wipe queued flags one thread per cycle
            t_we    = 1'b1;
            t_waddr = clr_ff;
            if (clr_ff == TW'(NUM_THREADS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               tid_in  = TW'(req_data.thread_id);
               lvl_in  = req_level;
               t_raddr = TW'(req_data.thread_id);
               case (req_data.mode)
                  prq_pkg::MODE_ENQUEUE: begin
                     if (tid_oob) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{out_thread: '0, status: prq_pkg::ST_ABSENT};
                     end else begin
                        state_in = S_ENQ_CHK;
                     end
                  end
                  prq_pkg::MODE_DEQUEUE: begin
                     word_in  = WW'(MW - 1);
                     state_in = S_DEQ_SCAN;
                  end
                  prq_pkg::MODE_REMOVE: begin
                     if (tid_oob) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{out_thread: '0, status: prq_pkg::ST_ABSENT};
                     end else begin
                        state_in = S_REM_CHK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{out_thread: '0, status: prq_pkg::ST_OK};
                  end
               endcase
            end
         end
         S_ENQ_CHK: begin
            if (rd_queued) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_thread: '0, status: prq_pkg::ST_DUPLICATE};
               state_in     = S_IDLE;
            end else begin
               t_we    = 1'b1;
               t_wdata = {LINK_END, lvl_ff, 1'b1};
               if (!mask_ff[lvl_ff]) begin
                  // empty level: thread becomes head and tail
                  l_we             = 1'b1;
                  l_wdata          = {tid_ff, tid_ff};
                  mask_in[lvl_ff]  = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '{out_thread: '0, status: prq_pkg::ST_OK};
                  state_in         = S_IDLE;
               end else begin
                  state_in = S_ENQ_TAIL;
               end
            end
         end
         S_ENQ_TAIL: begin
            // new tail, then link the old tail to it
            tail_in  = rd_tail;
            l_we     = 1'b1;
            l_wdata  = {rd_head, tid_ff};
            t_raddr  = rd_tail;
            state_in = S_ENQ_LINK;
         end
         S_ENQ_LINK: begin
            t_we         = 1'b1;
            t_waddr      = tail_ff;
            t_wdata      = {NW'(tid_ff), rd_level, rd_queued};
            rsp_valid_in = 1'b1;
            rsp_in       = '{out_thread: '0, status: prq_pkg::ST_OK};
            state_in     = S_IDLE;
         end
         S_DEQ_SCAN: begin
            // one mask word per cycle from the top
            if (scan_word != 32'd0) begin
               lvl_in   = LW'({word_ff, find_msb(scan_word)});
               l_raddr  = LW'({word_ff, find_msb(scan_word)});
               state_in = S_DEQ_HEAD;
            end else if (word_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_thread: '0, status: prq_pkg::ST_EMPTY};
               state_in     = S_IDLE;
            end else begin
               word_in = word_ff - 1'b1;
            end
         end
         S_DEQ_HEAD: begin
            tid_in   = rd_head;
            tail_in  = rd_tail;
            t_raddr  = rd_head;
            state_in = S_DEQ_POP;
         end
         S_DEQ_POP: begin
            l_we    = 1'b1;
            l_wdata = {rd_next[TW-1:0], tail_ff};
            if (rd_next >= LINK_END) begin
               mask_in[lvl_ff] = 1'b0;
            end
            t_we         = 1'b1;
            t_wdata      = {LINK_END, rd_level, 1'b0};
            rsp_valid_in = 1'b1;
            rsp_in       = '{out_thread: 6'(tid_ff), status: prq_pkg::ST_OK};
            state_in     = S_IDLE;
         end
         S_REM_CHK: begin
            if (!rd_queued) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_thread: '0, status: prq_pkg::ST_ABSENT};
               state_in     = S_IDLE;
            end else begin
               // drop the thread's own entry now, keep its link for the splice
               lvl_in   = rd_level;
               tnext_in = rd_next;
               t_we     = 1'b1;
               t_wdata  = {LINK_END, rd_level, 1'b0};
               l_raddr  = rd_level;
               state_in = S_REM_HEAD;
            end
         end
         S_REM_HEAD: begin
            head_in = rd_head;
            tail_in = rd_tail;
            if (rd_head == tid_ff) begin
               l_we    = 1'b1;
               l_wdata = {tnext_ff[TW-1:0], rd_tail};
               if (tnext_ff >= LINK_END) begin
                  mask_in[lvl_ff] = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_thread: '0, status: prq_pkg::ST_OK};
               state_in     = S_IDLE;
            end else begin
               prev_in  = rd_head;
               t_raddr  = rd_head;
               state_in = S_REM_WALK;
            end
         end
         S_REM_WALK: begin
            // follow links one entry per cycle until the thread is found or the list ends
            if (rd_next >= LINK_END) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_thread: '0, status: prq_pkg::ST_OK};
               state_in     = S_IDLE;
            end else if (rd_next[TW-1:0] == tid_ff) begin
               t_we    = 1'b1;
               t_waddr = prev_ff;
               t_wdata = {tnext_ff, rd_level, rd_queued};
               if (tail_ff == tid_ff) begin
                  l_we    = 1'b1;
                  l_wdata = {head_ff, prev_ff};
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_thread: '0, status: prq_pkg::ST_OK};
               state_in     = S_IDLE;
            end else begin
               prev_in = rd_next[TW-1:0];
               t_raddr = rd_next[TW-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff   <= tid_in;
      lvl_ff   <= lvl_in;
      word_ff  <= word_in;
      prev_ff  <= prev_in;
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      tnext_ff <= tnext_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/prq_ram.sv =====
// ----------------------------------------------------------------------------
// prq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
